// ----- rtl/core/ldfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ldfp_pkg
// shared types and constants for the lidar distance frame parser
// ----------------------------------------------------------------------------
package ldfp_pkg;

  // frame header byte
  localparam logic [7:0] HDR_BYTE = 8'h5C;
  // distance that the sensor reports when it sees no target
  localparam logic [15:0] NO_TARGET_MM = 16'd50000;
  // rounding offset for the mm to cm conversion
  localparam logic [16:0] ROUND_ADD = 17'd5;
  // ceil(2^19 / 10): floor(x * CM_RECIP >> 19) == x / 10 for x below 81920
  localparam logic [15:0] CM_RECIP = 16'hCCCD;
  localparam int unsigned CM_SHIFT = 19;

  // number of frame bytes held once a frame is complete up to its check byte
  localparam logic [1:0] FILL_FULL = 2'd3;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_GOOD  = 2'd1,
    ST_CKERR = 2'd2
  } status_e;

  // request passed from the front parser to the back end
  typedef struct packed {
    status_e     status;
    logic [15:0] dist_mm;
  } frame_req_t;

  // finished result as held in the output queue
  typedef struct packed {
    status_e     status;
    logic [15:0] dist_mm;
    logic [12:0] dist_cm;
    logic        in_range;
  } result_t;

endpackage

// ----- rtl/core/ldfp_fifo.sv -----
// ----------------------------------------------------------------------------
// ldfp_fifo
// small synchronous queue with full and empty flags
// ----------------------------------------------------------------------------
module ldfp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/ldfp_front.sv -----
// ----------------------------------------------------------------------------
// ldfp_front
// byte-serial frame hunter: header search, byte collection, checksum
// ----------------------------------------------------------------------------
module ldfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                req_full_i,
  output logic                req_push_o,
  output ldfp_pkg::frame_req_t req_o
);

  import ldfp_pkg::*;

  logic [1:0] fill_q, fill_d;
  logic [7:0] lo_q, lo_d;
  logic [7:0] hi_q, hi_d;
  logic [7:0] chk;
  logic [1:0] rf_fill0, rf_fill1;
  logic       take;

  assign take       = push_i && !req_full_i;
  assign req_push_o = take;
  assign chk        = ~(lo_q + hi_q);

  always_comb begin
    fill_d         = fill_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    rf_fill0       = '0;
    rf_fill1       = '0;
    req_o.status   = ST_NONE;
    req_o.dist_mm  = '0;
    if (fill_q != FILL_FULL) begin
      unique case (fill_q)
        2'd0: fill_d = (rx_byte_i == HDR_BYTE) ? 2'd1 : 2'd0;
        2'd1: begin
          lo_d   = rx_byte_i;
          fill_d = 2'd2;
        end
        default: begin
          hi_d   = rx_byte_i;
          fill_d = FILL_FULL;
        end
      endcase
    end else if (rx_byte_i == chk) begin
      req_o.status  = ST_GOOD;
      req_o.dist_mm = {hi_q, lo_q};
      fill_d        = '0;
    end else begin
      req_o.status = ST_CKERR;
      // rescan distance low, distance high and the bad check byte
      rf_fill0 = (lo_q == HDR_BYTE) ? 2'd1 : 2'd0;
      if (rf_fill0 == 2'd1) begin
        lo_d     = hi_q;
        rf_fill1 = 2'd2;
      end else begin
        rf_fill1 = (hi_q == HDR_BYTE) ? 2'd1 : 2'd0;
      end
      priority if (rf_fill1 == 2'd2) begin
        hi_d   = rx_byte_i;
        fill_d = FILL_FULL;
      end else if (rf_fill1 == 2'd1) begin
        lo_d   = rx_byte_i;
        fill_d = 2'd2;
      end else begin
        fill_d = (rx_byte_i == HDR_BYTE) ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (take) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

endmodule

// ----- rtl/core/ldfp_back.sv -----
// ----------------------------------------------------------------------------
// ldfp_back
// result builder: cm conversion by reciprocal multiply and range check
// ----------------------------------------------------------------------------
module ldfp_back (
  input  logic                 req_empty_i,
  input  ldfp_pkg::frame_req_t req_i,
  output logic                 req_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output ldfp_pkg::result_t    res_o
);

  import ldfp_pkg::*;

  logic [16:0] rounded;
  logic [32:0] prod;

  assign req_pop_o  = !req_empty_i && !res_full_i;
  assign res_push_o = req_pop_o;

  assign rounded = {1'b0, req_i.dist_mm} + ROUND_ADD;
  assign prod    = rounded * CM_RECIP;

  always_comb begin
    res_o.status   = req_i.status;
    res_o.dist_mm  = '0;
    res_o.dist_cm  = '0;
    res_o.in_range = 1'b0;
    if (req_i.status == ST_GOOD) begin
      res_o.dist_mm  = req_i.dist_mm;
      res_o.dist_cm  = prod[CM_SHIFT +: 13];
      res_o.in_range = (req_i.dist_mm != '0) && (req_i.dist_mm != NO_TARGET_MM);
    end
  end

endmodule

// ----- rtl/core/lidar_distance_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// lidar_distance_frame_parser_core
// parses 4-byte distance frames (header, low, high, check) from a byte stream
// ----------------------------------------------------------------------------
// usage
//   input side is a queue write port: drive rx_byte_i and raise push while
//   full is low; one byte is taken per such edge
//   output side is a queue read port: while empty is low the oldest result
//   sits on status_o, dist_mm_o, dist_cm_o and in_range_o; raise pop to take it
//   every byte produces exactly one result (no frame, good frame or checksum
//   error); on a checksum error the three bytes after the bad header are
//   rescanned inside the same cycle, so a frame starting there is kept
// timing
//   one byte per cycle sustained while full is low; the front parser writes
//   the request queue at the edge that takes the byte, and the back end moves
//   it from there to the result queue whenever the result queue is not full
//   the back end does the cm conversion with one 17x16 multiply per result
// reset and stalls
//   rst_ni clears the parser fill count and both queues; held frame bytes are
//   not cleared and are never read before being written
//   if the reader stops popping the result queue fills, then the request
//   queue, and full rises; nothing is dropped
// ----------------------------------------------------------------------------
module lidar_distance_frame_parser_core #(
  parameter int unsigned REQ_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input queue port
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // result queue port
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [15:0] dist_mm_o,
  output logic [12:0] dist_cm_o,
  output logic        in_range_o
);

  import ldfp_pkg::*;

  // front to request queue
  logic       fr_push;
  frame_req_t fr_req;
  logic       req_full;
  // request queue to back end
  logic       req_empty;
  logic       req_pop;
  frame_req_t req_head;
  // back end to result queue
  logic       res_full;
  logic       res_push;
  result_t    res_in;
  result_t    res_head;

  // input is stalled only by a full request queue
  assign full = req_full;

  // header hunt, byte collection and checksum, one byte per cycle while not full
  ldfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .req_full_i (req_full),
    .req_push_o (fr_push),
    .req_o      (fr_req)
  );

  // decouples the parser from the result builder
  ldfp_fifo #(
    .Width ($bits(frame_req_t)),
    .Depth (REQ_DEPTH)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_req),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .data_o  (req_head),
    .empty_o (req_empty)
  );

  // cm conversion and range flag
  ldfp_back u_back (
    .req_empty_i (req_empty),
    .req_i       (req_head),
    .req_pop_o   (req_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // finished results waiting for the reader
  ldfp_fifo #(
    .Width ($bits(result_t)),
    .Depth (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign status_o   = res_head.status;
  assign dist_mm_o  = res_head.dist_mm;
  assign dist_cm_o  = res_head.dist_cm;
  assign in_range_o = res_head.in_range;

endmodule

// ----- verif/ldfp_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ldfp_result_checker
// watches the byte and result queue ports of the frame parser, predicts the
// result of every accepted byte and compares it with what the block hands out
// ----------------------------------------------------------------------------
module ldfp_result_checker
  import ldfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] dist_mm_i,
  input  logic [12:0] dist_cm_i,
  input  logic        in_range_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned good_cnt_o,
  output int unsigned ckerr_cnt_o
);

  localparam logic [16:0] MM_PER_CM = 17'd10;

  logic [7:0]  held_bytes [3];
  logic [1:0]  held_cnt = 2'd0;
  result_t     frame_results_q [$];
  int unsigned mismatch_cnt;
  int unsigned good_seen;
  int unsigned ckerr_seen;

  task automatic load_partial(input logic [7:0] b);
    if (held_cnt == 2'd0) begin
      if (b == HDR_BYTE) begin
        held_bytes[0] = b;
        held_cnt      = 2'd1;
      end
    end else if (held_cnt != FILL_FULL) begin
      held_bytes[held_cnt] = b;
      held_cnt             = held_cnt + 2'd1;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    result_t     r;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  chk;
    logic [15:0] d;
    r        = '0;
    r.status = ST_NONE;
    if (held_cnt != FILL_FULL) begin
      load_partial(b);
    end else begin
      lo       = held_bytes[1];
      hi       = held_bytes[2];
      chk      = ~(lo + hi);
      held_cnt = 2'd0;
      if (b != chk) begin
        // bad frame: rescan the bytes after the header
        r.status = ST_CKERR;
        load_partial(lo);
        load_partial(hi);
        load_partial(b);
      end else begin
        d          = {hi, lo};
        r.status   = ST_GOOD;
        r.dist_mm  = d;
        r.dist_cm  = 13'(({1'b0, d} + ROUND_ADD) / MM_PER_CM);
        r.in_range = (d != 16'd0) && (d != NO_TARGET_MM);
      end
    end
    frame_results_q.push_back(r);
  endtask

  task automatic check_result();
    result_t exp_r;
    if (frame_results_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: result with nothing expected: status %0d mm %0d cm %0d rng %0b",
                 $realtime, status_i, dist_mm_i, dist_cm_i, in_range_i);
    end else begin
      exp_r = frame_results_q.pop_front();
      if (exp_r.status == ST_GOOD)  good_seen++;
      if (exp_r.status == ST_CKERR) ckerr_seen++;
      if (status_i != exp_r.status || dist_mm_i != exp_r.dist_mm ||
          dist_cm_i != exp_r.dist_cm || in_range_i != exp_r.in_range) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: exp status %0d mm %0d cm %0d rng %0b, got %0d %0d %0d %0b",
                   $realtime, exp_r.status, exp_r.dist_mm, exp_r.dist_cm, exp_r.in_range,
                   status_i, dist_mm_i, dist_cm_i, in_range_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 2'd0;
      frame_results_q.delete();
    end else begin
      if (pop_i && !empty_i) check_result();
      if (push_i && !full_i) predict_byte(rx_byte_i);
    end
    fail_cnt_o  <= mismatch_cnt;
    pending_o   <= frame_results_q.size();
    good_cnt_o  <= good_seen;
    ckerr_cnt_o <= ckerr_seen;
  end

endmodule

// ----- verif/lidar_distance_frame_parser_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_distance_frame_parser_core_tb
// feeds byte streams of good, corrupt and broken distance frames with random
// gaps and read stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module lidar_distance_frame_parser_core_tb;
  import ldfp_pkg::*;

  // generous cycle budget: every byte with a long gap and a long read stall
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned FRAME_BYTES  = 500;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte;
  logic        empty;
  logic        pop;
  logic [1:0]  status;
  logic [15:0] dist_mm;
  logic [12:0] dist_cm;
  logic        in_range;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned good_cnt;
  int unsigned ckerr_cnt;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  logic        burst_mode;

  lidar_distance_frame_parser_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte),
    .empty      (empty),
    .pop        (pop),
    .status_o   (status),
    .dist_mm_o  (dist_mm),
    .dist_cm_o  (dist_cm),
    .in_range_o (in_range)
  );

  ldfp_result_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .rx_byte_i   (rx_byte),
    .empty_i     (empty),
    .pop_i       (pop),
    .status_i    (status),
    .dist_mm_i   (dist_mm),
    .dist_cm_i   (dist_cm),
    .in_range_i  (in_range),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .good_cnt_o  (good_cnt),
    .ckerr_cnt_o (ckerr_cnt)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (burst_mode || r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // one byte request: optional gap with junk on the data lines, then hold
  // push until the block takes the byte
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_len();
    repeat (gap) begin
      push    <= 1'b0;
      rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
  endtask

  // complete frame, check byte right or corrupted
  task automatic send_frame(input logic [15:0] d, input logic corrupt);
    logic [7:0] chk;
    chk = ~(d[7:0] + d[15:8]);
    if (corrupt) chk = chk ^ 8'($urandom_range(255, 1));
    send_byte(HDR_BYTE);
    send_byte(d[7:0]);
    send_byte(d[15:8]);
    send_byte(chk);
    bytes_sent += 4;
  endtask

  // distances weighted toward the corners of the range
  function automatic logic [15:0] pick_dist();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)  return 16'd0;
    if (r < 16) return NO_TARGET_MM;
    if (r < 22) return 16'hFFFF;
    if (r < 32) return 16'($urandom_range(20));
    if (r < 38) return {HDR_BYTE, HDR_BYTE};
    return 16'($urandom);
  endfunction

  // result side: bursts of pop with random stalls in between
  initial begin
    int unsigned stall;
    int unsigned run;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_len();
      run   = $urandom_range(8, 1);
      repeat (stall) begin
        pop <= 1'b0;
        @(posedge clk);
      end
      repeat (run) begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    push       = 1'b0;
    rx_byte    = 8'h00;
    rst_n      = 1'b0;
    burst_mode = 1'b0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // idle junk, all zeros and all ones
    send_byte(8'h00);
    send_byte(8'hFF);
    // zero distance, out of range
    send_frame(16'd0, 1'b0);
    // no-target sentinel
    send_frame(NO_TARGET_MM, 1'b0);
    // largest distance, cm conversion at its top
    send_frame(16'hFFFF, 1'b0);
    // rounding boundary: 5 mm rounds up to 1 cm
    send_frame(16'd5, 1'b0);
    // bad check byte whose rescan starts a new frame on the second header
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'h34);
    send_byte(8'h12);
    send_byte(8'hB9);
    // header values carried as distance bytes
    send_frame({HDR_BYTE, HDR_BYTE}, 1'b0);
    // plain checksum failure
    send_frame(16'd1234, 1'b1);
    bytes_sent = 0;

    // ---- random part ----
    while (bytes_sent < FRAME_BYTES) begin
      burst_mode = ($urandom_range(99) < 20);
      kind       = $urandom_range(99);
      if (kind < 65) begin
        send_frame(pick_dist(), 1'b0);
      end else if (kind < 80) begin
        send_frame(pick_dist(), 1'b1);
      end else if (kind < 90) begin
        // truncated frame, the next one lands in the middle of it
        n = $urandom_range(2, 1);
        send_byte(HDR_BYTE);
        repeat (n) send_byte(8'($urandom));
        bytes_sent += n + 1;
      end else begin
        // line noise, sometimes with a stray header
        n = $urandom_range(4, 1);
        repeat (n) begin
          if ($urandom_range(99) < 25) send_byte(HDR_BYTE);
          else                         send_byte(8'($urandom));
        end
      end
    end
    push <= 1'b0;

    // wait for the last results, then drain for stray outputs
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("frames: %0d good, %0d checksum errors, over %0d frame bytes plus noise",
             good_cnt, ckerr_cnt, bytes_sent);
    $display("random gaps on the byte side and read stalls on the result side");
    if (fail_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
